// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/lsfws_pkg.sv -----
// ---------------------------------------------------------------------------
// lsfws_pkg
// Types and constants of the low-score flank window selector.
// ---------------------------------------------------------------------------
package lsfws_pkg;

    localparam int WINDOW_SIZE = 5;
    localparam int MID_INDEX   = WINDOW_SIZE / 2;
    localparam int FILL_W      = $clog2(WINDOW_SIZE + 1);
    localparam int POS_W       = 32;
    localparam int SCORE_W     = 17;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 17'd64881;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // register index = paddr / 4
    localparam logic [PADDR_W-3:0] REG_SCORE_THRESHOLD = '0;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic   func;
        pos_t   position;
        score_t score;
    } item_t;

    typedef struct packed {
        pos_t kept_position;
        logic last;
    } result_t;

    typedef struct packed {
        pos_t [WINDOW_SIZE-1:0] positions;
        logic [WINDOW_SIZE-1:0] mask;
    } job_t;

endpackage

// ----- sv/low_score_flank_window_selector.sv -----
// First result word: the job is written to the job queue, loaded into the back
// end's mask register, then registered as the output word. Items are taken one
// per cycle while the 2-deep job queue has room; a job emits one word per cycle
// while result_stall is low, and the next job is loaded once its mask is empty.
// Reset: window empty, kept marks cleared, threshold 64881; no clearing pass.
// ---------------------------------------------------------------------------
// low_score_flank_window_selector
// Sliding window selector with an APB threshold register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module low_score_flank_window_selector
    import lsfws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result
);

    score_t            threshold_reg;
    logic              cfg_write;
    logic              accept;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    job_t              push_job;
    job_t              pop_job;
    logic [FILL_W-1:0] fill;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (cfg_write && (paddr[PADDR_W-1:2] == REG_SCORE_THRESHOLD))
            threshold_reg <= pwdata[SCORE_W-1:0];
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_SCORE_THRESHOLD)
                  ? PDATA_W'(threshold_reg) : '0;

    assign item_stall = q_full;
    assign accept     = item_valid && !item_stall;

    lsfws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .threshold (threshold_reg),
        .push      (q_push),
        .job       (push_job),
        .fill      (fill)
    );

    lsfws_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    lsfws_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_job        (pop_job),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `ASSERT_IMPL(a_no_overflow, clk, rst_n, q_push, !q_full)
    `ASSERT_IMPL(a_no_underflow, clk, rst_n, q_pop, !q_empty)
    `ASSERT_NEXT(a_flush_empties, clk, rst_n, accept && (item.func == FUNC_FLUSH), fill == '0)
    `ASSERT_ALWAYS(a_fill_range, clk, rst_n, fill <= FILL_W'(WINDOW_SIZE))

endmodule

// ----- sv/lsfws_front.sv -----
// ---------------------------------------------------------------------------
// lsfws_front
// Holds the window, classifies each item and queues a job of entries to emit.
// ---------------------------------------------------------------------------
module lsfws_front
    import lsfws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  item_t             item,
    input  score_t            threshold,
    output logic              push,
    output job_t              job,
    output logic [FILL_W-1:0] fill
);

    pos_t                   pos_reg   [WINDOW_SIZE];
    score_t                 score_reg [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] kept_reg;
    logic [FILL_W-1:0]      fill_reg;

    pos_t                   pos_next   [WINDOW_SIZE];
    score_t                 score_next [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] kept_next;
    logic [FILL_W-1:0]      fill_next;

    logic [WINDOW_SIZE-1:0] kept_ins;
    logic [WINDOW_SIZE-1:0] check;
    logic [WINDOW_SIZE-1:0] valid;
    logic [WINDOW_SIZE-1:0] below;
    logic [WINDOW_SIZE-1:0] mask;
    logic [FILL_W-1:0]      fill_valid;
    logic                   low;

    always_comb
    begin
        pos_next   = pos_reg;
        score_next = score_reg;
        kept_ins   = kept_reg;
        fill_next  = fill_reg;
        fill_valid = fill_reg;
        check      = '0;
        if (item.func == FUNC_FLUSH)
        begin
            fill_next = '0;
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                if (fill_reg < FILL_W'(WINDOW_SIZE))
                    check[i] = 1'b1;
                else
                    check[i] = (i > MID_INDEX);
            end
        end
        else if (fill_reg < FILL_W'(WINDOW_SIZE))
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                if (FILL_W'(i) == fill_reg)
                begin
                    pos_next[i]   = item.position;
                    score_next[i] = item.score;
                    kept_ins[i]   = 1'b0;
                end
            end
            fill_next  = fill_reg + 1'b1;
            fill_valid = fill_next;
            // first fill checks the front half through the middle
            if (fill_next == FILL_W'(WINDOW_SIZE))
            begin
                for (int i = 0; i < WINDOW_SIZE; i++)
                    check[i] = (i <= MID_INDEX);
            end
        end
        else
        begin
            for (int i = 0; i < WINDOW_SIZE - 1; i++)
            begin
                pos_next[i]   = pos_reg[i+1];
                score_next[i] = score_reg[i+1];
                kept_ins[i]   = kept_reg[i+1];
            end
            pos_next[WINDOW_SIZE-1]   = item.position;
            score_next[WINDOW_SIZE-1] = item.score;
            kept_ins[WINDOW_SIZE-1]   = 1'b0;
            check[MID_INDEX]          = 1'b1;
        end

        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            valid[i] = (FILL_W'(i) < fill_valid);
            below[i] = (score_next[i] < threshold);
        end
        low  = |(check & valid & below);
        mask = low ? (valid & ~kept_ins) : '0;

        if (item.func == FUNC_FLUSH)
            kept_next = '0;
        else
            kept_next = kept_ins | mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            kept_reg <= kept_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg   <= pos_next;
            score_reg <= score_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
            job.positions[i] = pos_next[i];
        job.mask = mask;
    end

    assign push = accept & (|mask);
    assign fill = fill_reg;

endmodule

// ----- sv/lsfws_queue.sv -----
// ---------------------------------------------------------------------------
// lsfws_queue
// Short job queue between the classifying front and the emitting back.
// ---------------------------------------------------------------------------
module lsfws_queue
    import lsfws_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    assign pop_job = mem[rd_ptr_reg];
    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);

endmodule

// ----- sv/lsfws_back.sv -----
// ---------------------------------------------------------------------------
// lsfws_back
// Walks a job's mask oldest entry first and emits one word per marked entry.
// ---------------------------------------------------------------------------
module lsfws_back
    import lsfws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  job_t    q_job,
    input  logic    q_empty,
    output logic    q_pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    pos_t [WINDOW_SIZE-1:0] pos_reg;
    logic [WINDOW_SIZE-1:0] mask_reg;
    logic [WINDOW_SIZE-1:0] mask_next;
    logic                   out_valid_reg;
    result_t                out_reg;

    logic [WINDOW_SIZE-1:0] pick;
    logic                   load_out;
    pos_t                   pick_pos;

    // lowest set bit = oldest entry
    always_comb
    begin
        pick = '0;
        for (int i = WINDOW_SIZE - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick    = '0;
                pick[i] = 1'b1;
            end
        end
        pick_pos = '0;
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            if (pick[i])
                pick_pos = pick_pos | pos_reg[i];
        end
    end

    assign load_out  = (|mask_reg) && (!out_valid_reg || !result_stall);
    assign mask_next = mask_reg & ~pick;
    assign q_pop     = (mask_reg == '0) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                mask_reg <= q_job.mask;
            else if (load_out)
                mask_reg <= mask_next;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            pos_reg <= q_job.positions;
        if (load_out)
        begin
            out_reg.kept_position <= pick_pos;
            out_reg.last          <= (mask_next == '0);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- tb/sv/low_score_flank_window_selector_test.sv -----
// ---------------------------------------------------------------------------
// low_score_flank_window_selector_test
// Streams (position, score) items into the window selector and checks every
// kept-position word against a cycle-free model of the sliding window. The
// threshold register is reprogrammed over APB between traffic phases.
// ---------------------------------------------------------------------------
module low_score_flank_window_selector_test;
    import lsfws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCORE_MAX = (1 << SCORE_W) - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 250;
    localparam int PEND_CAP = 1024;
    localparam int EXP_CAP = 1024;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               item_valid = 1'b0;
    logic               item_stall;
    item_t              item = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    result_t            result;

    low_score_flank_window_selector u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    // window model
    pos_t                   win_pos [WINDOW_SIZE];
    score_t                 win_score [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] win_kept = '0;
    int                     fill_cnt = 0;
    score_t                 cfg_threshold = THRESHOLD_RESET;

    item_t   pend_mem [PEND_CAP];
    int      pend_wr = 0;
    int      pend_rd = 0;
    result_t exp_mem [EXP_CAP];
    int      exp_wr = 0;
    int      exp_rd = 0;
    result_t want_word;
    int      fail_count = 0;

    int gap_left = 0;
    int burst_left = 0;

    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   stall_mode = 0;
    int   mode_left = 0;

    // Queue a word for every held entry not yet kept, oldest first.
    function automatic void keep_unkept();
        int n_new;
        int k;
        n_new = 0;
        k = 0;
        for (int i = 0; i < fill_cnt; i++)
            if (!win_kept[i])
                n_new++;
        for (int i = 0; i < fill_cnt; i++)
        begin
            if (!win_kept[i])
            begin
                k++;
                exp_mem[exp_wr] = '{kept_position: win_pos[i], last: (k == n_new)};
                exp_wr++;
                win_kept[i] = 1'b1;
            end
        end
    endfunction

    function automatic void predict_selection(item_t w);
        logic low;
        low = 1'b0;
        if (w.func == FUNC_FLUSH)
        begin
            if (fill_cnt < WINDOW_SIZE)
            begin
                for (int i = 0; i < fill_cnt; i++)
                    if (win_score[i] < cfg_threshold)
                        low = 1'b1;
            end
            else
            begin
                for (int i = MID_INDEX + 1; i < WINDOW_SIZE; i++)
                    if (win_score[i] < cfg_threshold)
                        low = 1'b1;
            end
            if (low)
                keep_unkept();
            fill_cnt = 0;
            win_kept = '0;
        end
        else if (fill_cnt < WINDOW_SIZE)
        begin
            win_pos[fill_cnt] = w.position;
            win_score[fill_cnt] = w.score;
            win_kept[fill_cnt] = 1'b0;
            fill_cnt++;
            if (fill_cnt == WINDOW_SIZE)
            begin
                // first fill: front half through the middle
                for (int i = 0; i <= MID_INDEX; i++)
                    if (win_score[i] < cfg_threshold)
                        low = 1'b1;
                if (low)
                    keep_unkept();
            end
        end
        else
        begin
            for (int i = 0; i < WINDOW_SIZE - 1; i++)
            begin
                win_pos[i] = win_pos[i+1];
                win_score[i] = win_score[i+1];
                win_kept[i] = win_kept[i+1];
            end
            win_pos[WINDOW_SIZE-1] = w.position;
            win_score[WINDOW_SIZE-1] = w.score;
            win_kept[WINDOW_SIZE-1] = 1'b0;
            if (win_score[MID_INDEX] < cfg_threshold)
                keep_unkept();
        end
    endfunction

    // Driver: bursts of random length, random gaps in between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predict_selection(item);
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    item_valid <= 1'b0;
                end
                else if (pend_rd != pend_wr)
                begin
                    item <= pend_mem[pend_rd];
                    pend_rd = pend_rd + 1;
                    item_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: one long hold-off on request, otherwise random modes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
            stall_mode <= 0;
            mode_left <= 0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 120);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 1) == 0);
                default: result_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (exp_rd == exp_wr)
            begin
                $error("unexpected word: kept_position %h last %b",
                       result.kept_position, result.last);
                fail_count++;
            end
            else
            begin
                want_word = exp_mem[exp_rd];
                exp_rd++;
                if (result.kept_position !== want_word.kept_position)
                begin
                    $error("kept_position: expected %h, got %h",
                           want_word.kept_position, result.kept_position);
                    fail_count++;
                end
                if (result.last !== want_word.last)
                begin
                    $error("last: expected %b, got %b", want_word.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_item(logic fn, pos_t p, score_t s);
        pend_mem[pend_wr] = '{func: fn, position: p, score: s};
        pend_wr++;
    endtask

    // All words accepted and answered, then let the back end settle.
    task automatic drain();
        while (pend_rd != pend_wr || item_valid || exp_rd != exp_wr)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_SCORE_THRESHOLD, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_threshold = data[SCORE_W-1:0];
    endtask

    task automatic queue_random(int count);
        int     thr;
        int     sel;
        score_t s;
        pos_t   seq_pos;
        thr = int'(cfg_threshold);
        seq_pos = $urandom;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 3 && thr > 0)
                s = score_t'($urandom_range(0, thr - 1));
            else if (sel < 5)
            begin
                case ($urandom_range(0, 3))
                    0: s = '0;
                    1: s = 17'd65535;
                    2: s = 17'd65536;
                    default: s = '1;
                endcase
            end
            else if (sel < 8)
                s = score_t'($urandom_range(0, SCORE_MAX));
            else
                s = score_t'($urandom_range(thr, SCORE_MAX));
            seq_pos = seq_pos + 1;
            if ($urandom_range(0, 14) == 0)
                push_item(FUNC_FLUSH, $urandom, score_t'($urandom_range(0, SCORE_MAX)));
            else
                push_item(FUNC_INSERT, ($urandom_range(0, 1) == 0) ? seq_pos : pos_t'($urandom), s);
        end
    endtask

    initial
    begin
        logic [PDATA_W-1:0] settings [6];
        settings[0] = 32'd0;
        settings[1] = 32'd65536;
        settings[2] = SCORE_MAX;
        settings[3] = 32'hFFFE_0000 | 32'd40000;   // junk above the field
        settings[4] = $urandom_range(1, 65536);
        settings[5] = PDATA_W'(THRESHOLD_RESET);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty window flushes
        push_item(FUNC_FLUSH, '0, '0);
        push_item(FUNC_FLUSH, '1, '1);
        // partial window, low entry past the middle, threshold-equal is not low
        push_item(FUNC_INSERT, 32'h0000_0000, 17'd65536);
        push_item(FUNC_INSERT, 32'hFFFF_FFFF, 17'd131071);
        push_item(FUNC_INSERT, 32'h0000_0001, 17'd64881);
        push_item(FUNC_INSERT, 32'h0000_0002, 17'd64880);
        push_item(FUNC_FLUSH, 32'h1234_5678, 17'd0);
        // first fill with a low middle
        push_item(FUNC_INSERT, 32'd10, 17'd65536);
        push_item(FUNC_INSERT, 32'd11, 17'd65536);
        push_item(FUNC_INSERT, 32'd12, 17'd0);
        push_item(FUNC_INSERT, 32'd13, 17'd70000);
        push_item(FUNC_INSERT, 32'd14, 17'd65536);
        // shifts; low entry reaches the middle two shifts later
        push_item(FUNC_INSERT, 32'd15, 17'd65536);
        push_item(FUNC_INSERT, 32'd16, 17'd100);
        push_item(FUNC_INSERT, 32'd17, 17'd65536);
        push_item(FUNC_INSERT, 32'd18, 17'd65536);
        push_item(FUNC_INSERT, 32'd19, 17'd65536);
        push_item(FUNC_INSERT, 32'd20, 17'd5);
        // full window flush, low in the tail
        push_item(FUNC_FLUSH, '0, '0);
        // full window, nothing low
        push_item(FUNC_INSERT, 32'hA5A5_A5A5, 17'd65536);
        push_item(FUNC_INSERT, 32'h5A5A_5A5A, 17'd65536);
        push_item(FUNC_INSERT, 32'd3, 17'd65536);
        push_item(FUNC_INSERT, 32'd4, 17'd65536);
        push_item(FUNC_INSERT, 32'd5, 17'd65536);
        push_item(FUNC_FLUSH, '0, '0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_threshold(settings[ph]);
            queue_random(76);
            if (settings[ph] == SCORE_MAX)
            begin
                @(posedge clk);
                hold_req <= 1'b1;
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("low_score_flank_window_selector_test: clean");
        else
            $display("low_score_flank_window_selector_test: errors");
        $finish;
    end

    initial
    begin
        #500000;
        $display("low_score_flank_window_selector_test: errors");
        $finish;
    end

endmodule
